### sv/goi_pkg.sv
// ----------------------------------------------------------------------------
// goi_pkg : shared types and constants for the grid obstacle inflation block
// Beat payloads, controller/datapath command and status, register indexes
// and the occupancy-to-cost translation table.
// ----------------------------------------------------------------------------
package goi_pkg;

    localparam int COL_W      = 8;
    localparam int ROW_W      = 8;
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int MAX_COLS   = 256;
    localparam int MAX_ROWS   = 256;
    localparam int MAX_RADIUS = 15;
    localparam int RAD_W      = 4;
    localparam int DIM_W      = 9;
    localparam int STRIDE_W   = 4;
    localparam int CELL_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int MODC_W     = 3;

    localparam logic [DIM_W-1:0]    RST_MAP_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]    RST_MAP_HEIGHT = 9'd256;
    localparam logic [RAD_W-1:0]    RST_EXPLORE    = 4'd9;
    localparam logic [RAD_W-1:0]    RST_ADD        = 4'd5;
    localparam logic [RAD_W-1:0]    RST_PATH       = 4'd4;
    localparam logic [STRIDE_W-1:0] RST_STRIDE     = 4'd7;

    localparam logic signed [CELL_W-1:0] EXPLORE_MARK = 8'sd2;
    localparam logic [7:0]               COST_BLOCKED = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH      = 3'd0,
        CFG_MAP_HEIGHT     = 3'd1,
        CFG_EXPLORE_RADIUS = 3'd2,
        CFG_ADD_RADIUS     = 3'd3,
        CFG_PATH_RADIUS    = 3'd4,
        CFG_SAMPLE_STRIDE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                     action;
        logic [COL_W-1:0]         col;
        logic [ROW_W-1:0]         row;
        logic signed [CELL_W-1:0] cell_value;
    } t_goi_in;

    typedef struct packed {
        logic signed [CELL_W-1:0] explore_flag;
        logic [7:0]               add_cost;
        logic [7:0]               path_cost;
        logic                     is_sample_point;
        logic                     out_of_map;
    } t_goi_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_MOD,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_goi_state;

    typedef struct packed {
        logic accept;
        logic wr_cell;
        logic rd_centre;
        logic setup;
        logic mod_step;
        logic scan_rd;
        logic load_out;
    } t_goi_cmd;

    typedef struct packed {
        logic centre_zero;
        logic oom;
        logic mod_last;
        logic scan_last;
        logic out_free;
    } t_goi_sts;

    typedef logic [7:0] t_cost_lut [0:127];

    function automatic t_cost_lut build_cost_lut();
        t_cost_lut lut;
        int        c;
        for (int v = 0; v < 128; v++) begin
            if (v == 0)
                c = 0;
            else if (v == 1)
                c = 1;
            else if (v >= 100)
                c = 254;
            else if (v == 99)
                c = 253;
            else
                c = ((v - 1) * 251 - 1) / 97 + 1;
            lut[v] = 8'(c);
        end
        return lut;
    endfunction

    localparam t_cost_lut COST_LUT = build_cost_lut();

    // negative (unknown) cells cost as blocked
    function automatic logic [7:0] table_cost(logic signed [CELL_W-1:0] v);
        logic [7:0] c;
        c = v[CELL_W-1] ? COST_BLOCKED : COST_LUT[v[CELL_W-2:0]];
        return c;
    endfunction

    function automatic logic [RAD_W-1:0] clamp_rad(logic [RAD_W-1:0] r);
        logic [RAD_W-1:0] q;
        q = (int'(r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r;
        return q;
    endfunction

endpackage

### sv/goi_ctrl.sv
// ----------------------------------------------------------------------------
// goi_ctrl : sequencer for the grid obstacle inflation block
// Takes beats, steps a query through centre lookup, centre check, stride
// remainder, window scan and result load; drives the datapath by command.
// ----------------------------------------------------------------------------
module goi_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_action,
    input  goi_pkg::t_goi_sts   i_sts,
    output logic                o_in_stall,
    output goi_pkg::t_goi_cmd   o_cmd,
    output goi_pkg::t_goi_state o_state
);
    import goi_pkg::*;

    t_goi_state r_state;
    t_goi_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_action) begin
                        n_state = ST_LOOKUP;
                    end else begin
                        o_cmd.wr_cell = 1'b1;
                    end
                end
            end
            ST_LOOKUP: begin
                o_cmd.rd_centre = 1'b1;
                n_state         = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.setup = 1'b1;
                // only a free centre needs the window scan
                if (i_sts.oom || !i_sts.centre_zero) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_state    = r_state;

endmodule

### sv/goi_dp.sv
// ----------------------------------------------------------------------------
// goi_dp : datapath for the grid obstacle inflation block
// Cell store, configuration registers, window walker, stride remainder
// unit, hit accumulation and the result register.
// ----------------------------------------------------------------------------
module goi_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [goi_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [goi_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  goi_pkg::t_goi_in                    i_in_data,
    input  goi_pkg::t_goi_cmd                   i_cmd,
    input  logic                                i_out_stall,
    output goi_pkg::t_goi_sts                   o_sts,
    output logic                                o_out_valid,
    output goi_pkg::t_goi_out                   o_out_data
);
    import goi_pkg::*;

    // configuration
    logic [DIM_W-1:0]    r_map_w;
    logic [DIM_W-1:0]    r_map_h;
    logic [RAD_W-1:0]    r_re;
    logic [RAD_W-1:0]    r_ra;
    logic [RAD_W-1:0]    r_rp;
    logic [STRIDE_W-1:0] r_stride;

    // query
    logic [COL_W-1:0]         r_col;
    logic [ROW_W-1:0]         r_row;
    logic signed [CELL_W-1:0] r_v;

    // cell store
    logic [CELL_W-1:0] mem [0:MAX_COLS*MAX_ROWS-1];
    logic [CELL_W-1:0] r_rdata;
    logic [ADDR_W-1:0] rd_addr;

    // window walk
    logic [COL_W-1:0] r_x, r_x0, r_x1;
    logic [ROW_W-1:0] r_y, r_y1;
    logic             r_tag_vld;
    logic [RAD_W-1:0] r_tag_d;
    logic             r_hit_e, r_hit_a, r_hit_p;

    // stride remainders
    logic [COL_W-1:0]    r_mc;
    logic [ROW_W-1:0]    r_mr;
    logic [STRIDE_W-1:0] r_rem_c, r_rem_r;
    logic [MODC_W-1:0]   r_mod_cnt;
    logic                r_col_ge, r_row_ge;

    // result
    logic     r_out_valid;
    t_goi_out r_out_data;
    t_goi_out out_nxt;

    logic [DIM_W-1:0]    w_eff, h_eff;
    logic [RAD_W-1:0]    re_c, ra_c, rp_c, rmax;
    logic [COL_W-1:0]    x0;
    logic [ROW_W-1:0]    y0;
    logic [DIM_W-1:0]    xe, ye;
    logic [COL_W-1:0]    x1;
    logic [ROW_W-1:0]    y1;
    logic [COL_W-1:0]    dx;
    logic [ROW_W-1:0]    dy;
    logic [COL_W-1:0]    dmax;
    logic [STRIDE_W-2:0] off;
    logic                centre_free;

    function automatic logic [STRIDE_W-1:0] rem_step(
        logic [STRIDE_W-1:0] rem,
        logic                bit_in,
        logic [STRIDE_W-1:0] s
    );
        logic [STRIDE_W:0] t;
        logic [STRIDE_W:0] d;
        t = {rem, bit_in};
        d = t - {1'b0, s};
        return (t >= {1'b0, s}) ? d[STRIDE_W-1:0] : t[STRIDE_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w  <= RST_MAP_WIDTH;
            r_map_h  <= RST_MAP_HEIGHT;
            r_re     <= RST_EXPLORE;
            r_ra     <= RST_ADD;
            r_rp     <= RST_PATH;
            r_stride <= RST_STRIDE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAP_WIDTH:      r_map_w  <= i_cfg_data;
                CFG_MAP_HEIGHT:     r_map_h  <= i_cfg_data;
                CFG_EXPLORE_RADIUS: r_re     <= i_cfg_data[RAD_W-1:0];
                CFG_ADD_RADIUS:     r_ra     <= i_cfg_data[RAD_W-1:0];
                CFG_PATH_RADIUS:    r_rp     <= i_cfg_data[RAD_W-1:0];
                CFG_SAMPLE_STRIDE:  r_stride <= i_cfg_data[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff = (r_map_w > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : r_map_w;
        h_eff = (r_map_h > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : r_map_h;
        re_c  = clamp_rad(r_re);
        ra_c  = clamp_rad(r_ra);
        rp_c  = clamp_rad(r_rp);
        rmax  = (re_c > ra_c) ? re_c : ra_c;
        if (rp_c > rmax)
            rmax = rp_c;

        // window clipped to the map
        x0 = (r_col > COL_W'(rmax)) ? r_col - COL_W'(rmax) : '0;
        y0 = (r_row > ROW_W'(rmax)) ? r_row - ROW_W'(rmax) : '0;
        xe = {1'b0, r_col} + DIM_W'(rmax);
        ye = {1'b0, r_row} + DIM_W'(rmax);
        x1 = (xe < w_eff - 1'b1) ? xe[COL_W-1:0] : COL_W'(w_eff - 1'b1);
        y1 = (ye < h_eff - 1'b1) ? ye[ROW_W-1:0] : ROW_W'(h_eff - 1'b1);

        dx   = (r_x > r_col) ? r_x - r_col : r_col - r_x;
        dy   = (r_y > r_row) ? r_y - r_row : r_row - r_y;
        dmax = (dx > COL_W'(dy)) ? dx : COL_W'(dy);

        off = r_stride[STRIDE_W-1:1];

        rd_addr = i_cmd.scan_rd ? {r_y, r_x} : {r_row, r_col};
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_cell) begin
            mem[{i_in_data.row, i_in_data.col}] <= i_in_data.cell_value;
        end
        if (i_cmd.rd_centre || i_cmd.scan_rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_col <= i_in_data.col;
            r_row <= i_in_data.row;
        end

        if (i_cmd.setup) begin
            r_v       <= $signed(r_rdata);
            r_x       <= x0;
            r_x0      <= x0;
            r_x1      <= x1;
            r_y       <= y0;
            r_y1      <= y1;
            r_col_ge  <= (r_col >= COL_W'(off));
            r_row_ge  <= (r_row >= ROW_W'(off));
            r_mc      <= r_col - COL_W'(off);
            r_mr      <= r_row - ROW_W'(off);
            r_rem_c   <= '0;
            r_rem_r   <= '0;
            r_mod_cnt <= '0;
        end else if (i_cmd.mod_step) begin
            // restoring remainder, one dividend bit a cycle
            r_rem_c   <= rem_step(r_rem_c, r_mc[COL_W-1], r_stride);
            r_rem_r   <= rem_step(r_rem_r, r_mr[ROW_W-1], r_stride);
            r_mc      <= {r_mc[COL_W-2:0], 1'b0};
            r_mr      <= {r_mr[ROW_W-2:0], 1'b0};
            r_mod_cnt <= r_mod_cnt + 1'b1;
        end else if (i_cmd.scan_rd) begin
            r_tag_d <= dmax[RAD_W-1:0];
            if (r_x == r_x1) begin
                r_x <= r_x0;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end

        if (i_cmd.setup) begin
            r_hit_e <= 1'b0;
            r_hit_a <= 1'b0;
            r_hit_p <= 1'b0;
        end else if (r_tag_vld && (r_rdata != '0)) begin
            if (r_tag_d <= re_c) r_hit_e <= 1'b1;
            if (r_tag_d <= ra_c) r_hit_a <= 1'b1;
            if (r_tag_d <= rp_c) r_hit_p <= 1'b1;
        end

        if (i_cmd.load_out) begin
            r_out_data <= out_nxt;
        end
    end

    // tag marks a read whose data lands next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tag_vld <= i_cmd.scan_rd;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        centre_free = (r_v == '0);
        out_nxt     = '0;
        if (o_sts.oom) begin
            out_nxt.out_of_map = 1'b1;
        end else begin
            out_nxt.explore_flag = (centre_free && r_hit_e) ? EXPLORE_MARK : r_v;
            out_nxt.add_cost     = (centre_free && r_hit_a) ? COST_BLOCKED
                                                           : table_cost(r_v);
            out_nxt.path_cost    = (centre_free && r_hit_p) ? COST_BLOCKED
                                                           : table_cost(r_v);
            out_nxt.is_sample_point = (r_stride != '0) && centre_free && !r_hit_e
                                    && r_col_ge && r_row_ge
                                    && (r_rem_c == '0) && (r_rem_r == '0);
        end
    end

    assign o_sts.centre_zero = (r_rdata == '0);
    assign o_sts.oom         = ({1'b0, r_col} >= w_eff) || ({1'b0, r_row} >= h_eff);
    assign o_sts.mod_last    = (r_mod_cnt == MODC_W'(COL_W - 1));
    assign o_sts.scan_last   = (r_x == r_x1) && (r_y == r_y1);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### sv/grid_obstacle_inflation.sv
// ----------------------------------------------------------------------------
// grid_obstacle_inflation : occupancy grid with square obstacle inflation
// Stores grid cells and answers cell queries with explore mark, add and
// path costs, stride sample flag and out-of-map flag.
// ----------------------------------------------------------------------------
// Write beat: taken while idle, no result; writes may follow back to back.
// Free-cell query: steps through lookup, check, stride remainder, window scan, drain
//   and finish; the scan covers the clipped window cells (up to 31x31 = 961, 361 at
//   reset radii), read one a cycle from the store. Occupied/unknown or off-map query:
//   lookup, check, finish. Input stalls until the result loads, plus any output wait.
// Sync reset clears control and configuration; the cell store keeps contents.
module grid_obstacle_inflation (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  goi_pkg::t_goi_in               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output goi_pkg::t_goi_out              o_out_data,
    input  logic                           i_cfg_we,
    input  logic [goi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [goi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import goi_pkg::*;

    t_goi_cmd   w_cmd;
    t_goi_sts   w_sts;
    t_goi_state w_state;

    goi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    goi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // a result beat only ever appears after the finish step
    a_rise_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_state == ST_FINISH))
        else $error("result raised outside finish step");

    // a write beat never produces a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_in_data.action) |=> !$rose(o_out_valid))
        else $error("write beat produced a result");

    // off-map result carries only the flag
    a_oom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_of_map) |->
            (o_out_data.explore_flag == '0 && o_out_data.add_cost == '0 &&
             o_out_data.path_cost == '0 && !o_out_data.is_sample_point))
        else $error("off-map result with non-zero fields");

    // sample points sit on unmarked free cells only
    a_sample_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_sample_point) |->
            (o_out_data.explore_flag == '0))
        else $error("sample point on non-free cell");
`endif

endmodule
